@@ design/mmix_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor mixer package
// Shared types, register indexes, reset values and the frame sign table.
// ----------------------------------------------------------------------------
package mmix_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int FRAME_COUNT = 4;
    localparam int AXIS_COUNT  = 3;

    localparam int CMD_W   = 11;
    localparam int CORR_W  = 12;
    localparam int STICK_W = 12;
    localparam int TERM_W  = 13;
    localparam int MIX_W   = 15;
    localparam int LIM_W   = 17;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 3;

    typedef logic [CMD_W-1:0]          cmd_t;
    typedef logic signed [CORR_W-1:0]  corr_t;
    typedef logic [STICK_W-1:0]        stick_t;
    typedef logic signed [TERM_W-1:0]  term_t;
    typedef logic signed [MIX_W-1:0]   mix_t;
    typedef logic signed [LIM_W-1:0]   lim_t;
    typedef logic signed [1:0]         sign_t;
    typedef logic [IDX_W-1:0]          idx_t;

    localparam idx_t REG_FRAME_TYPE    = 3'd0;
    localparam idx_t REG_YAW_SIGN      = 3'd1;
    localparam idx_t REG_MIN_THROTTLE  = 3'd2;
    localparam idx_t REG_MAX_THROTTLE  = 3'd3;
    localparam idx_t REG_MIN_COMMAND   = 3'd4;
    localparam idx_t REG_MIN_CHECK     = 3'd5;
    localparam idx_t REG_IDLE_STOP     = 3'd6;

    localparam logic [1:0]  RST_FRAME_TYPE    = 2'd1;
    localparam logic [1:0]  RST_YAW_SIGN      = 2'd1;
    localparam cmd_t        RST_MIN_THROTTLE  = 11'd1150;
    localparam cmd_t        RST_MAX_THROTTLE  = 11'd1850;
    localparam cmd_t        RST_MIN_COMMAND   = 11'd1000;
    localparam stick_t      RST_MIN_CHECK     = 12'd1100;
    localparam logic        RST_IDLE_STOP     = 1'b0;

    localparam sign_t SIGN_P = 2'sb01;
    localparam sign_t SIGN_N = 2'sb11;
    localparam sign_t SIGN_Z = 2'sb00;

    // Per frame, per motor: roll, pitch and yaw weights.
    localparam sign_t MIX_SIGN [FRAME_COUNT][MOTOR_COUNT][AXIS_COUNT] = '{
        '{ '{SIGN_Z, SIGN_P, SIGN_N}, '{SIGN_N, SIGN_Z, SIGN_P},
           '{SIGN_P, SIGN_Z, SIGN_P}, '{SIGN_Z, SIGN_N, SIGN_N} },
        '{ '{SIGN_N, SIGN_P, SIGN_N}, '{SIGN_N, SIGN_N, SIGN_P},
           '{SIGN_P, SIGN_P, SIGN_P}, '{SIGN_P, SIGN_N, SIGN_N} },
        '{ '{SIGN_Z, SIGN_P, SIGN_N}, '{SIGN_N, SIGN_N, SIGN_Z},
           '{SIGN_Z, SIGN_P, SIGN_P}, '{SIGN_P, SIGN_N, SIGN_Z} },
        '{ '{SIGN_Z, SIGN_P, SIGN_P}, '{SIGN_N, SIGN_N, SIGN_Z},
           '{SIGN_Z, SIGN_P, SIGN_N}, '{SIGN_P, SIGN_N, SIGN_Z} }
    };

    typedef struct packed {
        logic [1:0] frame_type;
        logic [1:0] yaw_sign;
        cmd_t       min_throttle;
        cmd_t       max_throttle;
        cmd_t       min_command;
        stick_t     min_check;
        logic       idle_stop;
    } cfg_t;

    typedef struct packed {
        cmd_t   throttle_cmd;
        corr_t  roll_correction;
        corr_t  pitch_correction;
        corr_t  yaw_correction;
        stick_t throttle_stick;
        logic   armed;
        logic   baro_hold;
    } sample_t;

    function automatic term_t apply_sign(sign_t s, term_t x);
        term_t r;
        case (s)
            SIGN_P:  r = x;
            SIGN_N:  r = -x;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ design/mmix_mix.sv @@
// ----------------------------------------------------------------------------
// Motor mixer sum stage
// Weights the corrections by the frame sign table, adds the throttle command
// and finds the largest mixed motor value.
// ----------------------------------------------------------------------------
module mmix_mix (
    input  mmix_pkg::sample_t sample,
    input  mmix_pkg::cfg_t    cfg,
    output mmix_pkg::mix_t    mixed [mmix_pkg::MOTOR_COUNT],
    output mmix_pkg::mix_t    top
);

    mmix_pkg::term_t roll_term;
    mmix_pkg::term_t pitch_term;
    mmix_pkg::term_t yaw_term;
    mmix_pkg::mix_t  thr_term;

    assign roll_term  = mmix_pkg::term_t'(sample.roll_correction);
    assign pitch_term = mmix_pkg::term_t'(sample.pitch_correction);
    // Only the sign bit of the direction register counts.
    assign yaw_term   = cfg.yaw_sign[1] ? -mmix_pkg::term_t'(sample.yaw_correction)
                                        : mmix_pkg::term_t'(sample.yaw_correction);
    assign thr_term   = mmix_pkg::mix_t'({4'b0000, sample.throttle_cmd});

    always_comb
    begin
        for (int i = 0; i < mmix_pkg::MOTOR_COUNT; i++)
        begin
            mixed[i] = thr_term
                + mmix_pkg::mix_t'(mmix_pkg::apply_sign(
                      mmix_pkg::MIX_SIGN[cfg.frame_type][i][0], roll_term))
                + mmix_pkg::mix_t'(mmix_pkg::apply_sign(
                      mmix_pkg::MIX_SIGN[cfg.frame_type][i][1], pitch_term))
                + mmix_pkg::mix_t'(mmix_pkg::apply_sign(
                      mmix_pkg::MIX_SIGN[cfg.frame_type][i][2], yaw_term));
        end
    end

    always_comb
    begin
        top = mixed[0];
        for (int i = 1; i < mmix_pkg::MOTOR_COUNT; i++)
        begin
            if (mixed[i] > top)
            begin
                top = mixed[i];
            end
        end
    end

endmodule

@@ design/mmix_limit.sv @@
// ----------------------------------------------------------------------------
// Motor mixer limit stage
// Removes any excess above the maximum throttle, clamps each motor and
// applies the low stick and disarm overrides.
// ----------------------------------------------------------------------------
module mmix_limit (
    input  mmix_pkg::cfg_t    cfg,
    input  mmix_pkg::sample_t sample,
    input  mmix_pkg::mix_t    mixed [mmix_pkg::MOTOR_COUNT],
    input  mmix_pkg::mix_t    top,
    output mmix_pkg::cmd_t    motor [mmix_pkg::MOTOR_COUNT]
);

    mmix_pkg::lim_t lo;
    mmix_pkg::lim_t hi;
    mmix_pkg::lim_t top_l;
    logic           over;
    logic           low_stick;
    mmix_pkg::lim_t v [mmix_pkg::MOTOR_COUNT];

    assign lo        = mmix_pkg::lim_t'({1'b0, cfg.min_throttle});
    assign hi        = mmix_pkg::lim_t'({1'b0, cfg.max_throttle});
    assign top_l     = mmix_pkg::lim_t'(top);
    assign over      = top_l > hi;
    assign low_stick = (sample.throttle_stick < cfg.min_check) && !sample.baro_hold;

    always_comb
    begin
        for (int i = 0; i < mmix_pkg::MOTOR_COUNT; i++)
        begin
            v[i] = mmix_pkg::lim_t'(mixed[i]);
            if (over)
            begin
                v[i] = v[i] - top_l + hi;
            end
            if (v[i] < lo)
            begin
                v[i] = lo;
            end
            else if (v[i] > hi)
            begin
                v[i] = hi;
            end
            motor[i] = v[i][mmix_pkg::CMD_W-1:0];
            if (low_stick)
            begin
                motor[i] = cfg.idle_stop ? cfg.min_command : cfg.min_throttle;
            end
            if (!sample.armed)
            begin
                motor[i] = cfg.min_command;
            end
        end
    end

endmodule

@@ design/multirotor_motor_mixer_unit.sv @@
// ----------------------------------------------------------------------------
// Multirotor motor mixer unit
// Mixes one control sample into four motor commands for a four-motor frame.
// ----------------------------------------------------------------------------
// Each input item carries the throttle command, the roll, pitch and yaw
// corrections, the throttle stick, the armed flag and the baro hold flag.
// Each item gives exactly one output item with four motor commands.
// An item is taken into an input register, mixed and limited combinationally,
// and lands in the output register, raising out_valid. A new item is accepted
// in every cycle while in_stall is low. While out_stall is high the output
// item holds; the input register still takes one more item, and in_stall
// rises only once both registers are full. The user must write the
// configuration registers through cfg_write, cfg_index and cfg_data only while
// no item is in flight; the block does not enforce this. Writes to unused
// indexes are dropped. Reset empties both registers and loads the default
// frame (quad X), a positive yaw direction and the default throttle limits.
// ----------------------------------------------------------------------------
module multirotor_motor_mixer_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  mmix_pkg::idx_t        cfg_index,
    input  logic [mmix_pkg::CFG_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mmix_pkg::cmd_t        throttle_cmd,
    input  mmix_pkg::corr_t       roll_correction,
    input  mmix_pkg::corr_t       pitch_correction,
    input  mmix_pkg::corr_t       yaw_correction,
    input  mmix_pkg::stick_t      throttle_stick,
    input  logic                  armed,
    input  logic                  baro_hold,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mmix_pkg::cmd_t        motor_a,
    output mmix_pkg::cmd_t        motor_b,
    output mmix_pkg::cmd_t        motor_c,
    output mmix_pkg::cmd_t        motor_d
);

    mmix_pkg::cfg_t    cfg_reg;
    mmix_pkg::sample_t sample_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    mmix_pkg::cmd_t    motor_reg [mmix_pkg::MOTOR_COUNT];
    mmix_pkg::cmd_t    motor_next [mmix_pkg::MOTOR_COUNT];
    mmix_pkg::mix_t    mixed [mmix_pkg::MOTOR_COUNT];
    mmix_pkg::mix_t    top;
    logic              out_load;
    logic              in_accept;
    logic              s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_type    <= mmix_pkg::RST_FRAME_TYPE;
            cfg_reg.yaw_sign      <= mmix_pkg::RST_YAW_SIGN;
            cfg_reg.min_throttle  <= mmix_pkg::RST_MIN_THROTTLE;
            cfg_reg.max_throttle  <= mmix_pkg::RST_MAX_THROTTLE;
            cfg_reg.min_command   <= mmix_pkg::RST_MIN_COMMAND;
            cfg_reg.min_check     <= mmix_pkg::RST_MIN_CHECK;
            cfg_reg.idle_stop     <= mmix_pkg::RST_IDLE_STOP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mmix_pkg::REG_FRAME_TYPE:    cfg_reg.frame_type    <= cfg_data[1:0];
                mmix_pkg::REG_YAW_SIGN:      cfg_reg.yaw_sign      <= cfg_data[1:0];
                mmix_pkg::REG_MIN_THROTTLE:
                    cfg_reg.min_throttle <= cfg_data[mmix_pkg::CMD_W-1:0];
                mmix_pkg::REG_MAX_THROTTLE:
                    cfg_reg.max_throttle <= cfg_data[mmix_pkg::CMD_W-1:0];
                mmix_pkg::REG_MIN_COMMAND:
                    cfg_reg.min_command  <= cfg_data[mmix_pkg::CMD_W-1:0];
                mmix_pkg::REG_MIN_CHECK:
                    cfg_reg.min_check    <= cfg_data[mmix_pkg::STICK_W-1:0];
                mmix_pkg::REG_IDLE_STOP:     cfg_reg.idle_stop     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_load   = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !out_load;
    assign in_accept  = in_valid && !in_stall;
    assign s1_advance = s1_valid_reg && out_load;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !out_load);
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg.throttle_cmd     <= throttle_cmd;
            sample_reg.roll_correction  <= roll_correction;
            sample_reg.pitch_correction <= pitch_correction;
            sample_reg.yaw_correction   <= yaw_correction;
            sample_reg.throttle_stick   <= throttle_stick;
            sample_reg.armed            <= armed;
            sample_reg.baro_hold        <= baro_hold;
        end
    end

    mmix_mix u_mix (
        .sample (sample_reg),
        .cfg    (cfg_reg),
        .mixed  (mixed),
        .top    (top)
    );

    mmix_limit u_limit (
        .cfg    (cfg_reg),
        .sample (sample_reg),
        .mixed  (mixed),
        .top    (top),
        .motor  (motor_next)
    );

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            for (int i = 0; i < mmix_pkg::MOTOR_COUNT; i++)
            begin
                motor_reg[i] <= motor_next[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign motor_a   = motor_reg[0];
    assign motor_b   = motor_reg[1];
    assign motor_c   = motor_reg[2];
    assign motor_d   = motor_reg[3];

endmodule

@@ bench/mmix_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motor mixer checker
// Watches the register port and both item channels of the mixer. It keeps
// its own copy of the registers, works out the four motor commands for each
// accepted input item and compares them with each accepted output item.
// ----------------------------------------------------------------------------
module mmix_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  mmix_pkg::idx_t             cfg_index,
    input  logic [mmix_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  mmix_pkg::cmd_t             throttle_cmd,
    input  mmix_pkg::corr_t            roll_correction,
    input  mmix_pkg::corr_t            pitch_correction,
    input  mmix_pkg::corr_t            yaw_correction,
    input  mmix_pkg::stick_t           throttle_stick,
    input  logic                       armed,
    input  logic                       baro_hold,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  mmix_pkg::cmd_t             motor_a,
    input  mmix_pkg::cmd_t             motor_b,
    input  mmix_pkg::cmd_t             motor_c,
    input  mmix_pkg::cmd_t             motor_d,
    output int                         errors,
    output int                         pending,
    output int                         compared
);

    typedef logic [mmix_pkg::MOTOR_COUNT-1:0][mmix_pkg::CMD_W-1:0] motor_set_t;

    localparam logic [1:0] W_P = 2'b01;
    localparam logic [1:0] W_N = 2'b11;
    localparam logic [1:0] W_Z = 2'b00;

    localparam logic [1:0] FRAME_PLUS  = 2'd0;
    localparam logic [1:0] FRAME_X     = 2'd1;
    localparam logic [1:0] FRAME_Y4    = 2'd2;
    localparam logic [1:0] FRAME_VTAIL = 2'd3;

    mmix_pkg::cfg_t settings;
    motor_set_t     motor_expect_q[$];
    motor_set_t     want;
    motor_set_t     got;

    // Roll, pitch and yaw weights of one motor, each a signed 2-bit field.
    function automatic logic [5:0] mix_weights(input logic [1:0] frame,
                                               input logic [1:0] motor);
        logic [5:0] w;
        case ({frame, motor})
            {FRAME_PLUS, 2'd0}:  w = {W_Z, W_P, W_N};
            {FRAME_PLUS, 2'd1}:  w = {W_N, W_Z, W_P};
            {FRAME_PLUS, 2'd2}:  w = {W_P, W_Z, W_P};
            {FRAME_PLUS, 2'd3}:  w = {W_Z, W_N, W_N};
            {FRAME_X, 2'd0}:     w = {W_N, W_P, W_N};
            {FRAME_X, 2'd1}:     w = {W_N, W_N, W_P};
            {FRAME_X, 2'd2}:     w = {W_P, W_P, W_P};
            {FRAME_X, 2'd3}:     w = {W_P, W_N, W_N};
            {FRAME_Y4, 2'd0}:    w = {W_Z, W_P, W_N};
            {FRAME_Y4, 2'd1}:    w = {W_N, W_N, W_Z};
            {FRAME_Y4, 2'd2}:    w = {W_Z, W_P, W_P};
            {FRAME_Y4, 2'd3}:    w = {W_P, W_N, W_Z};
            {FRAME_VTAIL, 2'd0}: w = {W_Z, W_P, W_P};
            {FRAME_VTAIL, 2'd1}: w = {W_N, W_N, W_Z};
            {FRAME_VTAIL, 2'd2}: w = {W_Z, W_P, W_N};
            default:             w = {W_P, W_N, W_Z};
        endcase
        return w;
    endfunction

    function automatic motor_set_t mix_motors(input mmix_pkg::cmd_t thr,
                                              input mmix_pkg::corr_t roll,
                                              input mmix_pkg::corr_t pitch,
                                              input mmix_pkg::corr_t yaw,
                                              input mmix_pkg::stick_t stick,
                                              input logic arm,
                                              input logic baro);
        int         raw [mmix_pkg::MOTOR_COUNT];
        int         peak;
        int         lo;
        int         hi;
        int         ydir;
        int         v;
        int         i;
        logic [5:0] w;
        motor_set_t res;
        ydir = settings.yaw_sign[1] ? -1 : 1;
        lo = int'(settings.min_throttle);
        hi = int'(settings.max_throttle);
        for (i = 0; i < mmix_pkg::MOTOR_COUNT; i++)
        begin
            w = mix_weights(settings.frame_type, i[1:0]);
            raw[i] = int'(thr) + int'(roll) * int'($signed(w[5:4]))
                   + int'(pitch) * int'($signed(w[3:2]))
                   + ydir * int'(yaw) * int'($signed(w[1:0]));
        end
        peak = raw[0];
        for (i = 1; i < mmix_pkg::MOTOR_COUNT; i++)
        begin
            if (raw[i] > peak)
                peak = raw[i];
        end
        for (i = 0; i < mmix_pkg::MOTOR_COUNT; i++)
        begin
            v = raw[i];
            if (peak > hi)
                v = v - (peak - hi);
            if (v < lo)
                v = lo;
            else if (v > hi)
                v = hi;
            if (stick < settings.min_check && !baro)
                v = settings.idle_stop ? int'(settings.min_command) : lo;
            if (!arm)
                v = int'(settings.min_command);
            res[i] = mmix_pkg::cmd_t'(v);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_expect_q.delete();
            settings.frame_type    = mmix_pkg::RST_FRAME_TYPE;
            settings.yaw_sign      = mmix_pkg::RST_YAW_SIGN;
            settings.min_throttle  = mmix_pkg::RST_MIN_THROTTLE;
            settings.max_throttle  = mmix_pkg::RST_MAX_THROTTLE;
            settings.min_command   = mmix_pkg::RST_MIN_COMMAND;
            settings.min_check     = mmix_pkg::RST_MIN_CHECK;
            settings.idle_stop     = mmix_pkg::RST_IDLE_STOP;
            errors   = 0;
            compared = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {motor_d, motor_c, motor_b, motor_a};
                if (motor_expect_q.size() == 0)
                begin
                    errors++;
                    $display("%0d ns: expected no item, actual %0d %0d %0d %0d",
                             $time, got[0], got[1], got[2], got[3]);
                end
                else
                begin
                    want = motor_expect_q.pop_front();
                    compared++;
                    if (want[0] !== got[0] || want[1] !== got[1] ||
                        want[2] !== got[2] || want[3] !== got[3])
                    begin
                        errors++;
                        $display("%0d ns: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                                 $time, want[0], want[1], want[2], want[3],
                                 got[0], got[1], got[2], got[3]);
                    end
                end
            end
            if (in_valid && !in_stall)
                motor_expect_q.push_back(mix_motors(throttle_cmd, roll_correction,
                                                    pitch_correction, yaw_correction,
                                                    throttle_stick, armed, baro_hold));
            if (cfg_write)
            begin
                case (cfg_index)
                    mmix_pkg::REG_FRAME_TYPE:
                        settings.frame_type   = cfg_data[1:0];
                    mmix_pkg::REG_YAW_SIGN:
                        settings.yaw_sign     = cfg_data[1:0];
                    mmix_pkg::REG_MIN_THROTTLE:
                        settings.min_throttle = cfg_data[mmix_pkg::CMD_W-1:0];
                    mmix_pkg::REG_MAX_THROTTLE:
                        settings.max_throttle = cfg_data[mmix_pkg::CMD_W-1:0];
                    mmix_pkg::REG_MIN_COMMAND:
                        settings.min_command  = cfg_data[mmix_pkg::CMD_W-1:0];
                    mmix_pkg::REG_MIN_CHECK:
                        settings.min_check    = cfg_data[mmix_pkg::STICK_W-1:0];
                    mmix_pkg::REG_IDLE_STOP:
                        settings.idle_stop    = cfg_data[0];
                    default: ;
                endcase
            end
            pending <= motor_expect_q.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motor mixer testbench
// Drives control samples and register settings into the mixer, with random
// gaps on the input side and random stalls on the output side. A checker
// beside the block predicts and compares every motor item.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic [mmix_pkg::CFG_W-1:0] cfg_word_t;

    localparam mmix_pkg::idx_t REG_UNUSED = 3'd7;
    localparam int   PHASES       = 12;
    localparam int   RANDOM_ITEMS = 900;
    localparam int   HOLD_CYCLES  = 60;
    localparam int   BURST_ITEMS  = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    mmix_pkg::idx_t     cfg_index = '0;
    cfg_word_t          cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    mmix_pkg::cmd_t     throttle_cmd = '0;
    mmix_pkg::corr_t    roll_correction = '0;
    mmix_pkg::corr_t    pitch_correction = '0;
    mmix_pkg::corr_t    yaw_correction = '0;
    mmix_pkg::stick_t   throttle_stick = '0;
    logic               armed = 1'b0;
    logic               baro_hold = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    mmix_pkg::cmd_t     motor_a;
    mmix_pkg::cmd_t     motor_b;
    mmix_pkg::cmd_t     motor_c;
    mmix_pkg::cmd_t     motor_d;

    int             errors;
    int             pending;
    int             compared;
    int             items_sent = 0;
    int             hold_requests = 0;
    int             holds_done = 0;
    bit             no_idle = 1'b0;
    mmix_pkg::cfg_t cur;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    multirotor_motor_mixer_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .throttle_cmd     (throttle_cmd),
        .roll_correction  (roll_correction),
        .pitch_correction (pitch_correction),
        .yaw_correction   (yaw_correction),
        .throttle_stick   (throttle_stick),
        .armed            (armed),
        .baro_hold        (baro_hold),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .motor_a          (motor_a),
        .motor_b          (motor_b),
        .motor_c          (motor_c),
        .motor_d          (motor_d)
    );

    mmix_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .throttle_cmd     (throttle_cmd),
        .roll_correction  (roll_correction),
        .pitch_correction (pitch_correction),
        .yaw_correction   (yaw_correction),
        .throttle_stick   (throttle_stick),
        .armed            (armed),
        .baro_hold        (baro_hold),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .motor_a          (motor_a),
        .motor_b          (motor_b),
        .motor_c          (motor_c),
        .motor_d          (motor_d),
        .errors           (errors),
        .pending          (pending),
        .compared         (compared)
    );

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic mmix_pkg::sample_t sample_of(input int thr, input int roll,
                                                    input int pitch, input int yaw,
                                                    input int stick, input bit arm,
                                                    input bit baro);
        mmix_pkg::sample_t s;
        s.throttle_cmd     = mmix_pkg::cmd_t'(thr);
        s.roll_correction  = mmix_pkg::corr_t'(roll);
        s.pitch_correction = mmix_pkg::corr_t'(pitch);
        s.yaw_correction   = mmix_pkg::corr_t'(yaw);
        s.throttle_stick   = mmix_pkg::stick_t'(stick);
        s.armed            = arm;
        s.baro_hold        = baro;
        return s;
    endfunction

    function automatic mmix_pkg::corr_t random_corr();
        if ($urandom_range(0, 9) < 6)
            return mmix_pkg::corr_t'(int'($urandom_range(0, 800)) - 400);
        return mmix_pkg::corr_t'($urandom);
    endfunction

    function automatic mmix_pkg::sample_t random_sample();
        mmix_pkg::sample_t s;
        int                r;
        int                t;
        s.throttle_cmd = ($urandom_range(0, 9) < 6)
                       ? mmix_pkg::cmd_t'($urandom_range(1000, 2000))
                       : mmix_pkg::cmd_t'($urandom);
        s.roll_correction  = random_corr();
        s.pitch_correction = random_corr();
        s.yaw_correction   = random_corr();
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            s.throttle_stick =
                mmix_pkg::stick_t'($urandom_range(int'(cur.min_check), 4095));
        end
        else if (r < 82)
        begin
            t = int'(cur.min_check) - 2 + int'($urandom_range(0, 3));
            if (t < 0)
                t = 0;
            if (t > 4095)
                t = 4095;
            s.throttle_stick = mmix_pkg::stick_t'(t);
        end
        else
        begin
            s.throttle_stick = mmix_pkg::stick_t'($urandom);
        end
        s.armed     = ($urandom_range(0, 9) != 0);
        s.baro_hold = ($urandom_range(0, 9) < 3);
        return s;
    endfunction

    function automatic mmix_pkg::cfg_t phase_settings(input int ph);
        mmix_pkg::cfg_t c;
        c.frame_type = ph[1:0];
        case (ph)
            0:
            begin
                c.yaw_sign = 2'b01;
                c.min_throttle = 11'd1150; c.max_throttle = 11'd1850;
                c.min_command = 11'd1000;  c.min_check = 12'd1100;
                c.idle_stop = 1'b0;
            end
            1:
            begin
                c.yaw_sign = 2'b11;
                c.min_throttle = 11'd1000; c.max_throttle = 11'd2000;
                c.min_command = 11'd900;   c.min_check = 12'd1050;
                c.idle_stop = 1'b1;
            end
            2:
            begin
                c.yaw_sign = 2'b10;
                c.min_throttle = 11'd0;    c.max_throttle = 11'd2047;
                c.min_command = 11'd0;     c.min_check = 12'd0;
                c.idle_stop = 1'b0;
            end
            3:
            begin
                c.yaw_sign = 2'b00;
                c.min_throttle = 11'd2047; c.max_throttle = 11'd0;
                c.min_command = 11'd2047;  c.min_check = 12'd4095;
                c.idle_stop = 1'b1;
            end
            4:
            begin
                c.yaw_sign = 2'b01;
                c.min_throttle = 11'd1500; c.max_throttle = 11'd1200;
                c.min_command = 11'd1000;  c.min_check = 12'd2000;
                c.idle_stop = 1'b0;
            end
            default:
            begin
                c.frame_type   = 2'($urandom);
                c.yaw_sign     = 2'($urandom);
                c.min_throttle = ($urandom_range(0, 3) != 0)
                               ? mmix_pkg::cmd_t'($urandom_range(1000, 1300))
                               : mmix_pkg::cmd_t'($urandom);
                c.max_throttle = ($urandom_range(0, 3) != 0)
                               ? mmix_pkg::cmd_t'($urandom_range(1700, 2047))
                               : mmix_pkg::cmd_t'($urandom);
                c.min_command  = ($urandom_range(0, 3) != 0)
                               ? mmix_pkg::cmd_t'($urandom_range(900, 1100))
                               : mmix_pkg::cmd_t'($urandom);
                c.min_check    = ($urandom_range(0, 3) != 0)
                               ? mmix_pkg::stick_t'($urandom_range(1000, 1200))
                               : mmix_pkg::stick_t'($urandom);
                c.idle_stop    = 1'($urandom);
            end
        endcase
        return c;
    endfunction

    task automatic apply_settings(input mmix_pkg::cfg_t c);
        cfg_write <= 1'b1;
        cfg_index <= mmix_pkg::REG_FRAME_TYPE;
        cfg_data  <= cfg_word_t'(c.frame_type);
        @(posedge clk);
        cfg_index <= mmix_pkg::REG_YAW_SIGN;
        cfg_data  <= cfg_word_t'(c.yaw_sign);
        @(posedge clk);
        cfg_index <= mmix_pkg::REG_MIN_THROTTLE;
        cfg_data  <= cfg_word_t'(c.min_throttle);
        @(posedge clk);
        cfg_index <= mmix_pkg::REG_MAX_THROTTLE;
        cfg_data  <= cfg_word_t'(c.max_throttle);
        @(posedge clk);
        cfg_index <= mmix_pkg::REG_MIN_COMMAND;
        cfg_data  <= cfg_word_t'(c.min_command);
        @(posedge clk);
        cfg_index <= mmix_pkg::REG_MIN_CHECK;
        cfg_data  <= cfg_word_t'(c.min_check);
        @(posedge clk);
        cfg_index <= mmix_pkg::REG_IDLE_STOP;
        cfg_data  <= cfg_word_t'(c.idle_stop);
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= cfg_word_t'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        cur = c;
    endtask

    task automatic offer(input mmix_pkg::sample_t s);
        in_valid         <= 1'b1;
        throttle_cmd     <= s.throttle_cmd;
        roll_correction  <= s.roll_correction;
        pitch_correction <= s.pitch_correction;
        yaw_correction   <= s.yaw_correction;
        throttle_stick   <= s.throttle_stick;
        armed            <= s.armed;
        baro_hold        <= s.baro_hold;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic pause(input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Output side: random stalls, a long hold-off on request, none when asked.
    initial
    begin
        bit stall_now;
        int len;
        forever
        begin
            if (holds_done < hold_requests)
            begin
                stall_now = 1'b1;
                len = HOLD_CYCLES;
                holds_done++;
            end
            else if (no_idle)
            begin
                stall_now = 1'b0;
                len = 1;
            end
            else
            begin
                stall_now = ($urandom_range(0, 3) == 0);
                len = stall_now ? idle_len() : int'($urandom_range(1, 12));
            end
            out_stall <= stall_now;
            repeat (len) @(posedge clk);
        end
    end

    initial
    begin
        mmix_pkg::sample_t directed [$];
        int                ph;
        int                k;
        int                per_phase;
        int                gap;
        cur = phase_settings(0);
        cur.frame_type = mmix_pkg::RST_FRAME_TYPE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(sample_of(1500, 0, 0, 0, 2000, 1, 0));
        directed.push_back(sample_of(0, 0, 0, 0, 2000, 1, 0));
        directed.push_back(sample_of(2047, 0, 0, 0, 2000, 1, 0));
        directed.push_back(sample_of(1500, 2047, 0, 0, 2000, 1, 0));
        directed.push_back(sample_of(1500, -2048, 0, 0, 2000, 1, 0));
        directed.push_back(sample_of(1500, 0, 2047, 0, 2000, 1, 0));
        directed.push_back(sample_of(1500, 0, -2048, 0, 2000, 1, 0));
        directed.push_back(sample_of(1500, 0, 0, 2047, 2000, 1, 0));
        directed.push_back(sample_of(1500, 0, 0, -2048, 2000, 1, 0));
        directed.push_back(sample_of(2047, 2047, 2047, 2047, 4095, 1, 0));
        directed.push_back(sample_of(0, -2048, -2048, -2048, 4095, 1, 0));
        directed.push_back(sample_of(1800, 300, -200, 100, 1900, 1, 0));
        directed.push_back(sample_of(1400, 100, 50, -80, 1099, 1, 0));
        directed.push_back(sample_of(1400, 100, 50, -80, 1099, 1, 1));
        directed.push_back(sample_of(1400, 100, 50, -80, 1100, 1, 0));
        directed.push_back(sample_of(1400, -100, 50, 80, 0, 1, 0));
        directed.push_back(sample_of(1600, 200, 0, 0, 2000, 0, 0));
        directed.push_back(sample_of(1600, 200, 0, 0, 500, 0, 0));
        directed.push_back(sample_of(2047, -300, 300, 300, 4095, 0, 1));
        directed.push_back(sample_of(1200, 100, 100, -100, 1500, 1, 1));
        foreach (directed[i])
        begin
            offer(directed[i]);
            pause($urandom_range(0, 1) ? 0 : idle_len());
        end
        drain();

        per_phase = RANDOM_ITEMS / PHASES;
        for (ph = 0; ph < PHASES; ph++)
        begin
            apply_settings(phase_settings(ph));
            no_idle = (ph == 0);
            if (ph == 1)
                hold_requests++;
            for (k = 0; k < per_phase; k++)
            begin
                offer(random_sample());
                if (no_idle || (ph == 1 && k < BURST_ITEMS))
                    gap = 0;
                else
                    gap = $urandom_range(0, 1) ? 0 : idle_len();
                pause(gap);
            end
            no_idle = 1'b0;
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Covered %0d samples under %0d register settings: every frame and yaw code,",
                 items_sent, PHASES + 1);
        $display("low stick, baro hold, disarm, min above max and a held-off output; %0d checked.",
                 compared);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ multirotor_motor_mixer_unit.f @@
design/mmix_pkg.sv
design/mmix_mix.sv
design/mmix_limit.sv
design/multirotor_motor_mixer_unit.sv
bench/mmix_checker.sv
bench/tb_top.sv
